@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms. Each one samples on clk and uses rst
// from the scope where it is placed.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define OWBS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define OWBS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// Consequent must hold in the cycle after reset is seen.
`define OWBS_ASSERT_AFTER_RESET(label, cons) \
  label: assert property (@(posedge clk) rst |=> (cons)) \
    else $error("assertion failed after reset");

`endif

@@ rtl/core/owbs_pkg.sv @@
// ----------------------------------------------------------------------------
// One-wire backlight sender package
// Types, register indexes, reset values and the level scaling function.
// ----------------------------------------------------------------------------
package owbs_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;
  localparam int HOLD_W     = 12;
  localparam int LEVEL_W    = 8;
  localparam int CLAMP_W    = 6;
  localparam int DATA_W     = 5;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ADDRESS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_MODE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_US       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_US        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_HIGH_US  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_LOW_US   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_WAIT_US  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_OFF_HOLD_US    = 3'd7;

  // Register reset values.
  localparam logic [7:0]        RST_DEVICE_ADDRESS = 8'h72;
  localparam logic              RST_SCALE_MODE     = 1'b0;
  localparam logic [7:0]        RST_SHORT_US       = 8'd10;
  localparam logic [7:0]        RST_LONG_US        = 8'd40;
  localparam logic [HOLD_W-1:0] RST_ENTRY_HIGH_US  = 12'd300;
  localparam logic [HOLD_W-1:0] RST_ENTRY_LOW_US   = 12'd600;
  localparam logic [HOLD_W-1:0] RST_ENTRY_WAIT_US  = 12'd700;
  localparam logic [HOLD_W-1:0] RST_OFF_HOLD_US    = 12'd3000;

  localparam logic [CLAMP_W-1:0] MAX_LEVEL  = 6'd32;
  localparam logic [CLAMP_W-1:0] SCALE_KNEE = 6'd30;
  localparam logic [DATA_W-1:0]  CAP_MODE0  = 5'd26;
  localparam logic [DATA_W-1:0]  CAP_MODE1  = 5'd30;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_OFF,
    ST_ZERO,
    ST_ENTRY_HIGH,
    ST_ENTRY_LOW,
    ST_ENTRY_WAIT,
    ST_START,
    ST_BIT_LOW,
    ST_BIT_HIGH,
    ST_STOP,
    ST_TAIL
  } state_t;

  typedef enum logic [3:0] {
    SEG_OFF,
    SEG_ZERO,
    SEG_ENTRY_HIGH,
    SEG_ENTRY_LOW,
    SEG_ENTRY_WAIT,
    SEG_START,
    SEG_BIT_LOW,
    SEG_BIT_HIGH,
    SEG_STOP,
    SEG_TAIL
  } seg_kind_t;

  typedef struct packed {
    logic      accept;
    logic      emit;
    seg_kind_t seg;
    logic      last;
    logic      next_bit;
    logic      load_data;
    logic      set_mode;
    logic      clr_mode;
  } ctrl_cmd_t;

  typedef struct packed {
    logic panel_on;
    logic level_zero;
    logic in_mode;
    logic bit_done;
    logic second_byte;
    logic out_free;
  } ctrl_status_t;

  // Clamped level (0..32) to the five-bit data byte.
  function automatic logic [DATA_W-1:0] scale_level(input logic [CLAMP_W-1:0] lvl,
                                                    input logic mode);
    logic [CLAMP_W+1:0] triple;
    logic [DATA_W-1:0]  res;
    triple = {2'b00, lvl} + {1'b0, lvl, 1'b0};
    if (lvl >= SCALE_KNEE) begin
      res = mode ? CAP_MODE1 : CAP_MODE0;
    end else if (mode) begin
      res = lvl[DATA_W-1:0];
    end else begin
      res = triple[DATA_W+1:2];
    end
    return res;
  endfunction

endpackage

@@ rtl/core/owbs_if.sv @@
// ----------------------------------------------------------------------------
// One-wire backlight sender channels
// Brightness request channel and pin segment channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface owbs_req_if;
  logic       valid;
  logic       ready;
  logic [7:0] level;
  logic       panel_on;

  modport source (output valid, output level, output panel_on, input ready);
  modport sink   (input valid, input level, input panel_on, output ready);
endinterface

interface owbs_seg_if;
  logic        valid;
  logic        ready;
  logic        line_level;
  logic [11:0] hold_us;
  logic        last;

  modport source (output valid, output line_level, output hold_us, output last, input ready);
  modport sink   (input valid, input line_level, input hold_us, input last, output ready);
endinterface

@@ rtl/core/owbs_ctrl.sv @@
// ----------------------------------------------------------------------------
// One-wire backlight sender controller
// Walks the segment sequence of one request and drives the datapath.
// ----------------------------------------------------------------------------
module owbs_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     req_valid,
  output logic                     req_ready,
  input  owbs_pkg::ctrl_status_t   status,
  output owbs_pkg::ctrl_cmd_t      cmd
);

  owbs_pkg::state_t state;
  owbs_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= owbs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      owbs_pkg::ST_IDLE: begin
        if (req_valid) state_next = owbs_pkg::ST_DECIDE;
      end
      owbs_pkg::ST_DECIDE: begin
        if (!status.panel_on) begin
          state_next = owbs_pkg::ST_OFF;
        end else if (status.level_zero) begin
          state_next = owbs_pkg::ST_ZERO;
        end else if (!status.in_mode) begin
          state_next = owbs_pkg::ST_ENTRY_HIGH;
        end else begin
          state_next = owbs_pkg::ST_START;
        end
      end
      owbs_pkg::ST_OFF, owbs_pkg::ST_ZERO: begin
        if (status.out_free) state_next = owbs_pkg::ST_IDLE;
      end
      owbs_pkg::ST_ENTRY_HIGH: begin
        if (status.out_free) state_next = owbs_pkg::ST_ENTRY_LOW;
      end
      owbs_pkg::ST_ENTRY_LOW: begin
        if (status.out_free) state_next = owbs_pkg::ST_ENTRY_WAIT;
      end
      owbs_pkg::ST_ENTRY_WAIT: begin
        if (status.out_free) state_next = owbs_pkg::ST_START;
      end
      owbs_pkg::ST_START: begin
        if (status.out_free) state_next = owbs_pkg::ST_BIT_LOW;
      end
      owbs_pkg::ST_BIT_LOW: begin
        if (status.out_free) state_next = owbs_pkg::ST_BIT_HIGH;
      end
      owbs_pkg::ST_BIT_HIGH: begin
        if (status.out_free) begin
          state_next = status.bit_done ? owbs_pkg::ST_STOP : owbs_pkg::ST_BIT_LOW;
        end
      end
      owbs_pkg::ST_STOP: begin
        if (status.out_free) state_next = owbs_pkg::ST_TAIL;
      end
      owbs_pkg::ST_TAIL: begin
        if (status.out_free) begin
          state_next = status.second_byte ? owbs_pkg::ST_IDLE : owbs_pkg::ST_START;
        end
      end
      default: state_next = owbs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    cmd.seg   = owbs_pkg::SEG_OFF;
    req_ready = 1'b0;
    unique case (state)
      owbs_pkg::ST_IDLE: begin
        req_ready  = 1'b1;
        cmd.accept = req_valid;
      end
      owbs_pkg::ST_DECIDE: begin
        cmd.emit = 1'b0;
      end
      owbs_pkg::ST_OFF: begin
        cmd.emit = status.out_free;
        cmd.seg  = owbs_pkg::SEG_OFF;
        cmd.last = 1'b1;
      end
      owbs_pkg::ST_ZERO: begin
        cmd.emit     = status.out_free;
        cmd.seg      = owbs_pkg::SEG_ZERO;
        cmd.last     = 1'b1;
        cmd.clr_mode = status.out_free;
      end
      owbs_pkg::ST_ENTRY_HIGH: begin
        cmd.emit = status.out_free;
        cmd.seg  = owbs_pkg::SEG_ENTRY_HIGH;
      end
      owbs_pkg::ST_ENTRY_LOW: begin
        cmd.emit = status.out_free;
        cmd.seg  = owbs_pkg::SEG_ENTRY_LOW;
      end
      owbs_pkg::ST_ENTRY_WAIT: begin
        cmd.emit     = status.out_free;
        cmd.seg      = owbs_pkg::SEG_ENTRY_WAIT;
        cmd.set_mode = status.out_free;
      end
      owbs_pkg::ST_START: begin
        cmd.emit = status.out_free;
        cmd.seg  = owbs_pkg::SEG_START;
      end
      owbs_pkg::ST_BIT_LOW: begin
        cmd.emit = status.out_free;
        cmd.seg  = owbs_pkg::SEG_BIT_LOW;
      end
      owbs_pkg::ST_BIT_HIGH: begin
        cmd.emit     = status.out_free;
        cmd.seg      = owbs_pkg::SEG_BIT_HIGH;
        cmd.next_bit = status.out_free;
      end
      owbs_pkg::ST_STOP: begin
        cmd.emit = status.out_free;
        cmd.seg  = owbs_pkg::SEG_STOP;
      end
      owbs_pkg::ST_TAIL: begin
        cmd.emit      = status.out_free;
        cmd.seg       = owbs_pkg::SEG_TAIL;
        cmd.last      = status.second_byte;
        cmd.load_data = status.out_free && !status.second_byte;
      end
      default: cmd = '0;
    endcase
  end

endmodule

@@ rtl/core/owbs_datapath.sv @@
// ----------------------------------------------------------------------------
// One-wire backlight sender datapath
// Configuration registers, request registers, bit shifter and output register.
// ----------------------------------------------------------------------------
module owbs_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [owbs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [owbs_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic [owbs_pkg::LEVEL_W-1:0]       req_level,
  input  logic                               req_panel_on,
  input  owbs_pkg::ctrl_cmd_t                cmd,
  output owbs_pkg::ctrl_status_t             status,
  input  logic                               seg_ready,
  output logic                               seg_valid,
  output logic                               seg_line_level,
  output logic [owbs_pkg::HOLD_W-1:0]        seg_hold_us,
  output logic                               seg_last
);

  logic [7:0]                   device_address;
  logic                         scale_mode;
  logic [7:0]                   short_us;
  logic [7:0]                   long_us;
  logic [owbs_pkg::HOLD_W-1:0]  entry_high_us;
  logic [owbs_pkg::HOLD_W-1:0]  entry_low_us;
  logic [owbs_pkg::HOLD_W-1:0]  entry_wait_us;
  logic [owbs_pkg::HOLD_W-1:0]  off_hold_us;

  logic                         panel_on;
  logic                         level_zero;
  logic                         in_mode;
  logic [owbs_pkg::DATA_W-1:0]  data_byte;
  logic [7:0]                   shifter;
  logic [2:0]                   bit_count;
  logic                         second_byte;

  logic [owbs_pkg::CLAMP_W-1:0] level_clamped;
  logic                         seg_level_d;
  logic [owbs_pkg::HOLD_W-1:0]  seg_hold_d;
  logic [owbs_pkg::HOLD_W-1:0]  short_ext;
  logic [owbs_pkg::HOLD_W-1:0]  long_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= owbs_pkg::RST_DEVICE_ADDRESS;
      scale_mode     <= owbs_pkg::RST_SCALE_MODE;
      short_us       <= owbs_pkg::RST_SHORT_US;
      long_us        <= owbs_pkg::RST_LONG_US;
      entry_high_us  <= owbs_pkg::RST_ENTRY_HIGH_US;
      entry_low_us   <= owbs_pkg::RST_ENTRY_LOW_US;
      entry_wait_us  <= owbs_pkg::RST_ENTRY_WAIT_US;
      off_hold_us    <= owbs_pkg::RST_OFF_HOLD_US;
    end else if (cfg_we) begin
      unique case (cfg_index)
        owbs_pkg::CFG_DEVICE_ADDRESS: device_address <= cfg_data[7:0];
        owbs_pkg::CFG_SCALE_MODE:     scale_mode     <= cfg_data[0];
        owbs_pkg::CFG_SHORT_US:       short_us       <= cfg_data[7:0];
        owbs_pkg::CFG_LONG_US:        long_us        <= cfg_data[7:0];
        owbs_pkg::CFG_ENTRY_HIGH_US:  entry_high_us  <= cfg_data;
        owbs_pkg::CFG_ENTRY_LOW_US:   entry_low_us   <= cfg_data;
        owbs_pkg::CFG_ENTRY_WAIT_US:  entry_wait_us  <= cfg_data;
        owbs_pkg::CFG_OFF_HOLD_US:    off_hold_us    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign level_clamped = (req_level > {2'b00, owbs_pkg::MAX_LEVEL}) ?
                         owbs_pkg::MAX_LEVEL : req_level[owbs_pkg::CLAMP_W-1:0];

  // Request registers and the byte shifter; the address byte goes first.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      panel_on    <= req_panel_on;
      level_zero  <= (req_level == '0);
      data_byte   <= owbs_pkg::scale_level(level_clamped, scale_mode);
      shifter     <= device_address;
      bit_count   <= '0;
      second_byte <= 1'b0;
    end else if (cmd.next_bit) begin
      shifter   <= {shifter[6:0], 1'b0};
      bit_count <= bit_count + 3'd1;
    end else if (cmd.load_data) begin
      shifter     <= {3'b000, data_byte};
      bit_count   <= '0;
      second_byte <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_mode <= 1'b0;
    end else if (cmd.set_mode) begin
      in_mode <= 1'b1;
    end else if (cmd.clr_mode) begin
      in_mode <= 1'b0;
    end
  end

  assign short_ext = {4'b0000, short_us};
  assign long_ext  = {4'b0000, long_us};

  always_comb begin
    seg_level_d = 1'b0;
    seg_hold_d  = '0;
    unique case (cmd.seg)
      owbs_pkg::SEG_OFF: begin
        seg_level_d = 1'b0;
        seg_hold_d  = '0;
      end
      owbs_pkg::SEG_ZERO: begin
        seg_level_d = 1'b0;
        seg_hold_d  = off_hold_us;
      end
      owbs_pkg::SEG_ENTRY_HIGH: begin
        seg_level_d = 1'b1;
        seg_hold_d  = entry_high_us;
      end
      owbs_pkg::SEG_ENTRY_LOW: begin
        seg_level_d = 1'b0;
        seg_hold_d  = entry_low_us;
      end
      owbs_pkg::SEG_ENTRY_WAIT: begin
        seg_level_d = 1'b1;
        seg_hold_d  = entry_wait_us;
      end
      owbs_pkg::SEG_START: begin
        seg_level_d = 1'b1;
        seg_hold_d  = short_ext;
      end
      owbs_pkg::SEG_BIT_LOW: begin
        seg_level_d = 1'b0;
        seg_hold_d  = shifter[7] ? short_ext : long_ext;
      end
      owbs_pkg::SEG_BIT_HIGH: begin
        seg_level_d = 1'b1;
        seg_hold_d  = shifter[7] ? long_ext : short_ext;
      end
      owbs_pkg::SEG_STOP: begin
        seg_level_d = 1'b0;
        seg_hold_d  = short_ext;
      end
      owbs_pkg::SEG_TAIL: begin
        seg_level_d = 1'b1;
        seg_hold_d  = '0;
      end
      default: begin
        seg_level_d = 1'b0;
        seg_hold_d  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seg_valid <= 1'b0;
    end else if (cmd.emit) begin
      seg_valid <= 1'b1;
    end else if (seg_ready) begin
      seg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      seg_line_level <= seg_level_d;
      seg_hold_us    <= seg_hold_d;
      seg_last       <= cmd.last;
    end
  end

  always_comb begin
    status.panel_on    = panel_on;
    status.level_zero  = level_zero;
    status.in_mode     = in_mode;
    status.bit_done    = (bit_count == 3'd7);
    status.second_byte = second_byte;
    status.out_free    = !seg_valid || seg_ready;
  end

endmodule

@@ rtl/core/one_wire_backlight_sender_top.sv @@
// ----------------------------------------------------------------------------
// One-wire backlight sender
// Turns brightness requests into timed pin segments for a one-wire backlight
// controller.
// ----------------------------------------------------------------------------
//  Channel   Direction  Carries                          Handshake
//  req       in         level[7:0], panel_on             valid/ready
//  seg       out        line_level, hold_us[11:0], last  valid/ready
//  cfg       in         cfg_we, cfg_index[2:0], cfg_data  write enable only
//
// A request is taken in the idle state and decoded in the decide state. A
// panel-off or zero-level request gives a single segment; any other gives two
// byte frames, after the mode entry sequence if the line is not in one-wire
// mode. The single output register takes one segment a cycle while seg is
// ready. A stall on seg holds the controller in place; a new request is taken
// only once the final segment is in the output register. Reset is synchronous
// and returns the registers to their defaults and the line to normal mode.
// ----------------------------------------------------------------------------
module one_wire_backlight_sender_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [owbs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [owbs_pkg::CFG_DATA_W-1:0] cfg_data,
  owbs_req_if.sink                        req,
  owbs_seg_if.source                      seg
);

  // Commands from the controller and status back from the datapath.
  owbs_pkg::ctrl_cmd_t    cmd;
  owbs_pkg::ctrl_status_t status;

  // The controller steps through the segment sequence of one request: the
  // optional mode entry phases, then two byte frames of start, eight bits of
  // two phases each, stop and a final high with no hold time.
  owbs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // The datapath keeps the configuration, the decoded request, the bit
  // shifter and the output register that feeds the segment channel.
  owbs_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .req_level      (req.level),
    .req_panel_on   (req.panel_on),
    .cmd            (cmd),
    .status         (status),
    .seg_ready      (seg.ready),
    .seg_valid      (seg.valid),
    .seg_line_level (seg.line_level),
    .seg_hold_us    (seg.hold_us),
    .seg_last       (seg.last)
  );

endmodule

@@ rtl/core/owbs_checker.sv @@
// ----------------------------------------------------------------------------
// One-wire backlight sender checker
// Port-level assertions on the request and segment channels.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module owbs_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        seg_valid,
  input logic        seg_ready,
  input logic        seg_line_level,
  input logic [11:0] seg_hold_us,
  input logic        seg_last
);

  // All segment fields side by side, so that one check covers them.
  logic [13:0] seg_word;

  assign seg_word = {seg_line_level, seg_hold_us, seg_last};

  // A waiting segment keeps its contents until it is taken.
  `OWBS_ASSERT_NEXT(a_seg_hold, seg_valid && !seg_ready, seg_valid && $stable(seg_word))

  // The block is busy in the cycle after taking a request.
  `OWBS_ASSERT_NEXT(a_req_busy, req_valid && req_ready, !req_ready)

  // While a segment that is not the final one waits, no request is taken.
  `OWBS_ASSERT_NOW(a_mid_request, seg_valid && !seg_last, !req_ready)

  // Reset empties the output register.
  `OWBS_ASSERT_AFTER_RESET(a_reset_empty, !seg_valid)

endmodule

bind one_wire_backlight_sender_top owbs_checker u_owbs_checker (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req.valid),
  .req_ready      (req.ready),
  .seg_valid      (seg.valid),
  .seg_ready      (seg.ready),
  .seg_line_level (seg.line_level),
  .seg_hold_us    (seg.hold_us),
  .seg_last       (seg.last)
);

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// One-wire backlight sender testbench
// Drives brightness requests into the sender and checks every pin segment
// that comes back against a cycle-free prediction of the segment train,
// across several register settings, random idling on both channels and
// one long receiver hold-off that fills the block and stalls its input.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Brightness clamp and scaling figures of the one-wire protocol.
  localparam logic [5:0] LEVEL_CEIL  = 6'd32;
  localparam int         KNEE        = 30;
  localparam int         CAP_QUARTER = 26;
  localparam int         CAP_FULL    = 30;

  typedef struct packed {
    logic [7:0] level;
    logic       panel_on;
  } bright_req_t;

  typedef struct packed {
    logic        line_level;
    logic [11:0] hold_us;
    logic        last;
  } segment_t;

  logic                            clk = 1'b0;
  logic                            rst;
  logic                            cfg_we;
  logic [owbs_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [owbs_pkg::CFG_DATA_W-1:0] cfg_data;

  owbs_req_if req_ch ();
  owbs_seg_if seg_ch ();

  one_wire_backlight_sender_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .seg       (seg_ch)
  );

  // Clock: 2 ns period. Inputs move on the falling edge, outputs are sampled
  // on the rising edge, so nothing depends on event order within a step.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Requests still to be offered, and the segments the block owes us.
  bright_req_t pending_reqs[$];
  segment_t    seg_expect[$];

  // Shadow copy of the register file, kept in step with every write.
  logic [7:0]  sh_address;
  logic        sh_scale;
  logic [7:0]  sh_short;
  logic [7:0]  sh_long;
  logic [11:0] sh_entry_high;
  logic [11:0] sh_entry_low;
  logic [11:0] sh_entry_wait;
  logic [11:0] sh_off_hold;

  // Shadow copy of the line state: whether the chip has been put into
  // one-wire mode, and the last clamped level taken with the panel on.
  logic        sh_one_wire;
  logic [5:0]  sh_brightness;

  int  errors      = 0;
  int  reqs_taken  = 0;
  bit  req_hs      = 1'b0;  // a request was taken at the last rising edge
  bit  idle_on     = 1'b1;  // random gaps enabled on both channels
  bit  hold_off    = 1'b0;  // long receiver hold-off in progress
  int  req_gap     = 0;
  int  seg_stall   = 0;

  // Gap length in cycles: mostly none, sometimes a few, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  function automatic void add_seg(logic lvl, logic [11:0] hold, logic fin);
    seg_expect.push_back('{lvl, hold, fin});
  endfunction

  // One byte frame: start, eight bits MSB first, end of stream, idle high.
  // A one bit is a short low then a long high; a zero bit the other way round.
  function automatic void add_byte(logic [7:0] value, logic fin);
    logic [11:0] s;
    logic [11:0] l;
    s = {4'd0, sh_short};
    l = {4'd0, sh_long};
    add_seg(1'b1, s, 1'b0);
    for (int k = 7; k >= 0; k--) begin
      if (value[k]) begin
        add_seg(1'b0, s, 1'b0);
        add_seg(1'b1, l, 1'b0);
      end else begin
        add_seg(1'b0, l, 1'b0);
        add_seg(1'b1, s, 1'b0);
      end
    end
    add_seg(1'b0, s, 1'b0);
    add_seg(1'b1, 12'd0, fin);
  endfunction

  // Works out the whole segment train that one request causes.
  function automatic void plan_segments(logic [7:0] level, logic panel_on);
    logic [5:0] clamped;
    logic [4:0] data_byte;
    int         lv;
    if (!panel_on) begin
      // Panel unpowered: park the line low, state untouched.
      add_seg(1'b0, 12'd0, 1'b1);
      return;
    end
    clamped = (level > {2'b00, LEVEL_CEIL}) ? LEVEL_CEIL : level[5:0];
    sh_brightness = clamped;
    if (clamped == 6'd0) begin
      // Zero brightness drops the chip out of one-wire mode.
      add_seg(1'b0, sh_off_hold, 1'b1);
      sh_one_wire = 1'b0;
      return;
    end
    if (!sh_one_wire) begin
      add_seg(1'b1, sh_entry_high, 1'b0);
      add_seg(1'b0, sh_entry_low, 1'b0);
      add_seg(1'b1, sh_entry_wait, 1'b0);
      sh_one_wire = 1'b1;
    end
    add_byte(sh_address, 1'b0);
    lv = clamped;
    if (!sh_scale) data_byte = (lv >= KNEE) ? 5'(CAP_QUARTER) : 5'(lv * 3 / 4);
    else           data_byte = (lv >= KNEE) ? 5'(CAP_FULL) : 5'(lv);
    add_byte({3'b000, data_byte}, 1'b1);
  endfunction

  // Register write on the falling edge; the block takes it at the next rising
  // edge. Only called while the block is idle, so the shadow moves at once.
  task automatic write_reg(input logic [owbs_pkg::CFG_IDX_W-1:0] idx,
                           input logic [11:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      owbs_pkg::CFG_DEVICE_ADDRESS: sh_address    = value[7:0];
      owbs_pkg::CFG_SCALE_MODE:     sh_scale      = value[0];
      owbs_pkg::CFG_SHORT_US:       sh_short      = value[7:0];
      owbs_pkg::CFG_LONG_US:        sh_long       = value[7:0];
      owbs_pkg::CFG_ENTRY_HIGH_US:  sh_entry_high = value;
      owbs_pkg::CFG_ENTRY_LOW_US:   sh_entry_low  = value;
      owbs_pkg::CFG_ENTRY_WAIT_US:  sh_entry_wait = value;
      owbs_pkg::CFG_OFF_HOLD_US:    sh_off_hold   = value;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic program_regs(input logic [11:0] addr, input logic [11:0] mode,
                              input logic [11:0] short_v, input logic [11:0] long_v,
                              input logic [11:0] e_high, input logic [11:0] e_low,
                              input logic [11:0] e_wait, input logic [11:0] off_v);
    write_reg(owbs_pkg::CFG_DEVICE_ADDRESS, addr);
    write_reg(owbs_pkg::CFG_SCALE_MODE, mode);
    write_reg(owbs_pkg::CFG_SHORT_US, short_v);
    write_reg(owbs_pkg::CFG_LONG_US, long_v);
    write_reg(owbs_pkg::CFG_ENTRY_HIGH_US, e_high);
    write_reg(owbs_pkg::CFG_ENTRY_LOW_US, e_low);
    write_reg(owbs_pkg::CFG_ENTRY_WAIT_US, e_wait);
    write_reg(owbs_pkg::CFG_OFF_HOLD_US, off_v);
  endtask

  function automatic void push_req(logic [7:0] level, logic panel_on);
    pending_reqs.push_back('{level, panel_on});
  endfunction

  // Random requests. Most are powered, nonzero levels that exercise the byte
  // frames; zero levels knock the line out of one-wire mode so that the entry
  // sequence keeps coming back; out-of-range levels, levels from the whole
  // byte range and panel-off requests make up the rest.
  task automatic queue_random(input int n, input bit idle);
    int r;
    logic [7:0] lvl;
    idle_on = idle;
    @(posedge clk);
    repeat (n) begin
      r = $urandom_range(99);
      if (r < 45)      lvl = 8'($urandom_range(32, 1));
      else if (r < 58) lvl = 8'd0;
      else if (r < 72) lvl = 8'($urandom_range(255, 33));
      else             lvl = 8'($urandom_range(255, 0));
      push_req(lvl, ($urandom_range(99) < 85) ? 1'b1 : 1'b0);
    end
  endtask

  // Waits until every request has been offered and taken and every expected
  // segment has come back, then lets the controller settle before any write.
  task automatic wait_drained();
    while (pending_reqs.size() != 0 || req_ch.valid || seg_expect.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Request driver. A request that has been offered stays up until it is
  // taken; after that the gap chosen for it runs out before the next one.
  always @(negedge clk) begin : drive_requests
    bright_req_t item;
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (req_ch.valid && !req_hs) begin
      // Still waiting for the block to take the current request.
    end else if (req_gap > 0) begin
      req_ch.valid <= 1'b0;
      req_gap--;
    end else if (pending_reqs.size() != 0) begin
      item = pending_reqs.pop_front();
      req_ch.valid    <= 1'b1;
      req_ch.level    <= item.level;
      req_ch.panel_on <= item.panel_on;
      req_gap = pick_gap();
    end else begin
      req_ch.valid <= 1'b0;
    end
  end

  // Segment receiver. Ready drops for random stretches, and for the whole of
  // the long hold-off.
  always @(negedge clk) begin : drive_ready
    if (rst || hold_off) begin
      seg_ch.ready <= 1'b0;
    end else if (seg_stall > 0) begin
      seg_ch.ready <= 1'b0;
      seg_stall--;
    end else begin
      seg_ch.ready <= 1'b1;
      seg_stall = pick_gap();
    end
  end

  // One long hold-off on the segment channel while requests keep coming: the
  // output register fills, the controller stalls and the request channel
  // backs up behind it.
  initial begin : long_hold
    while (reqs_taken < 30) @(posedge clk);
    hold_off = 1'b1;
    repeat (400) @(posedge clk);
    hold_off = 1'b0;
  end

  // Monitor: predicts on each request taken and checks each segment taken,
  // in order, field by field.
  always @(posedge clk) begin : watch
    segment_t got;
    segment_t want;
    req_hs = !rst && req_ch.valid && req_ch.ready;
    if (req_hs) begin
      plan_segments(req_ch.level, req_ch.panel_on);
      reqs_taken++;
    end
    if (!rst && seg_ch.valid && seg_ch.ready) begin
      got = {seg_ch.line_level, seg_ch.hold_us, seg_ch.last};
      if (seg_expect.size() == 0) begin
        if (errors < 40)
          $display("%0t: segment with none expected: expected nothing, actual %0b/%0d/%0b",
                   $time, got.line_level, got.hold_us, got.last);
        errors++;
      end else begin
        want = seg_expect.pop_front();
        if (got.line_level !== want.line_level) begin
          if (errors < 40)
            $display("%0t: line_level mismatch: expected %0b, actual %0b",
                     $time, want.line_level, got.line_level);
          errors++;
        end
        if (got.hold_us !== want.hold_us) begin
          if (errors < 40)
            $display("%0t: hold_us mismatch: expected %0d, actual %0d",
                     $time, want.hold_us, got.hold_us);
          errors++;
        end
        if (got.last !== want.last) begin
          if (errors < 40)
            $display("%0t: last mismatch: expected %0b, actual %0b",
                     $time, want.last, got.last);
          errors++;
        end
      end
    end
  end

  // Stimulus: reset, a directed set at the default registers, then random
  // phases under minimum, maximum, random, zero-length and default timing settings.
  initial begin : stimulus
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    req_ch.valid    = 1'b0;
    req_ch.level    = 8'd0;
    req_ch.panel_on = 1'b0;
    seg_ch.ready    = 1'b0;

    sh_address    = owbs_pkg::RST_DEVICE_ADDRESS;
    sh_scale      = owbs_pkg::RST_SCALE_MODE;
    sh_short      = owbs_pkg::RST_SHORT_US;
    sh_long       = owbs_pkg::RST_LONG_US;
    sh_entry_high = owbs_pkg::RST_ENTRY_HIGH_US;
    sh_entry_low  = owbs_pkg::RST_ENTRY_LOW_US;
    sh_entry_wait = owbs_pkg::RST_ENTRY_WAIT_US;
    sh_off_hold   = owbs_pkg::RST_OFF_HOLD_US;
    sh_one_wire   = 1'b0;
    sh_brightness = 6'd0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed requests at the reset register values.
    push_req(8'd255, 1'b0);  // panel off, line parked low, no bytes sent
    push_req(8'd0,   1'b1);  // zero level, off hold
    push_req(8'd1,   1'b1);  // first nonzero level brings the entry sequence
    push_req(8'd1,   1'b1);  // already in one-wire mode, no entry
    push_req(8'd0,   1'b0);  // panel off leaves the mode as it is
    push_req(8'd2,   1'b1);
    push_req(8'd4,   1'b1);
    push_req(8'd8,   1'b1);
    push_req(8'd16,  1'b1);
    push_req(8'd29,  1'b1);  // just below the knee
    push_req(8'd30,  1'b1);  // at the knee, capped
    push_req(8'd31,  1'b1);
    push_req(8'd32,  1'b1);  // top of the range
    push_req(8'd33,  1'b1);  // clamped to 32
    push_req(8'd64,  1'b1);
    push_req(8'd128, 1'b1);
    push_req(8'd255, 1'b1);
    push_req(8'd0,   1'b1);  // back out of one-wire mode
    push_req(8'd5,   1'b1);  // entry sequence again
    push_req(8'd3,   1'b1);
    wait_drained();

    // Minimum timings, full-level scaling, address zero, no off hold.
    program_regs(12'h000, 12'h001, 12'd1, 12'd1, 12'd1, 12'd1, 12'd1, 12'd0);
    queue_random(50, 1'b1);
    wait_drained();

    // Maximum timings; upper data bits beyond each register must be dropped,
    // which also brings scaling back to three quarters.
    program_regs(12'hFFF, 12'hFFE, 12'hFFF, 12'd255, 12'd4095, 12'd4095, 12'd4095, 12'd4095);
    queue_random(50, 1'b0);
    wait_drained();

    // Random settings within range.
    program_regs(12'($urandom_range(255)), 12'($urandom_range(1)),
                 12'($urandom_range(255, 1)), 12'($urandom_range(255, 1)),
                 12'($urandom_range(4095, 1)), 12'($urandom_range(4095, 1)),
                 12'($urandom_range(4095, 1)), 12'($urandom_range(4095)));
    queue_random(50, 1'b1);
    wait_drained();

    // A short phase masked down to zero is passed through as given.
    program_regs(12'($urandom_range(255)), 12'h001, 12'h100,
                 12'($urandom_range(255, 1)), 12'($urandom_range(4095, 1)),
                 12'($urandom_range(4095, 1)), 12'($urandom_range(4095, 1)), 12'd0);
    queue_random(30, 1'b1);
    wait_drained();

    // Default timings written back explicitly, with full-level scaling.
    program_regs({4'd0, owbs_pkg::RST_DEVICE_ADDRESS}, 12'h001,
                 {4'd0, owbs_pkg::RST_SHORT_US}, {4'd0, owbs_pkg::RST_LONG_US},
                 owbs_pkg::RST_ENTRY_HIGH_US, owbs_pkg::RST_ENTRY_LOW_US,
                 owbs_pkg::RST_ENTRY_WAIT_US, owbs_pkg::RST_OFF_HOLD_US);
    queue_random(80, 1'b1);
    wait_drained();

    // Anything still coming out now has no request behind it.
    repeat (20) @(negedge clk);
    if (errors == 0 && seg_expect.size() == 0) begin
      $display("PASS one_wire_backlight_sender_top");
    end else begin
      $display("FAIL one_wire_backlight_sender_top");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin : watchdog
    #4_000_000;
    $display("FAIL one_wire_backlight_sender_top");
    $finish;
  end

endmodule
